[rtl/binary_to_decimal_ascii_formatter_defines.svh]
// Assertion macros used by the checker file.
`ifndef BINARY_TO_DECIMAL_ASCII_FORMATTER_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_FORMATTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define BDAF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("formatter check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is held.
`define BDAF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("formatter check failed: next-cycle rule");

`endif

[rtl/bdaf_pkg.sv]
package bdaf_pkg;

    // Field widths
    localparam int WHOLE_BITS      = 32;
    localparam int FRACTION_BITS   = 20;
    localparam int FRACTION_DIGITS = 6;

    // Decimal digits needed for the largest whole value (log10(2) ~ 0.30103)
    localparam int BCD_DIGITS = (WHOLE_BITS * 30103) / 100000 + 1;
    localparam int BCD_BITS   = 4 * BCD_DIGITS;

    // Counter and index widths
    localparam int CNT_W  = $clog2(WHOLE_BITS);
    localparam int IDX_W  = $clog2(BCD_DIGITS);
    localparam int FCNT_W = $clog2(FRACTION_DIGITS + 1);

    // Character codes
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'd57;
    localparam logic [7:0] ASCII_MINUS = 8'd45;
    localparam logic [7:0] ASCII_POINT = 8'd46;

    // Mode codes
    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_FIXED    = 1'b1;

    // One converted number handed from the converter to the character sequencer
    typedef struct packed {
        logic                     opcode;
        logic                     minus;
        logic [FRACTION_BITS-1:0] fraction;
        logic [BCD_BITS-1:0]      bcd;
    } t_job;

endpackage

[rtl/bdaf_dabble.sv]
module bdaf_dabble (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_opcode,
    input  logic                            i_negative,
    input  logic [bdaf_pkg::WHOLE_BITS-1:0]    i_whole,
    input  logic [bdaf_pkg::FRACTION_BITS-1:0] i_fraction,
    output logic                            o_valid,
    input  logic                            i_ready,
    output bdaf_pkg::t_job                  o_job
);
    import bdaf_pkg::*;

    localparam logic [1:0] DB_IDLE = 2'd0;
    localparam logic [1:0] DB_RUN  = 2'd1;
    localparam logic [1:0] DB_DONE = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [WHOLE_BITS-1:0] r_bin, n_bin;
    t_job                  r_job, n_job;
    logic [BCD_BITS-1:0]   v_adj;

    // Add three to every BCD digit of five or more (independent per digit)
    always_comb begin
        logic [3:0] v_digit;
        v_adj = r_job.bcd;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            v_digit = r_job.bcd[4*d +: 4];
            if (v_digit >= 4'd5) begin
                v_adj[4*d +: 4] = v_digit + 4'd3;
            end
        end
    end

    // Sequence: capture, shift one bit per cycle, then hold until taken
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bin   = r_bin;
        n_job   = r_job;
        unique case (r_state)
            DB_IDLE: begin
                if (i_valid) begin
                    n_job.opcode   = i_opcode;
                    n_job.minus    = (i_opcode == OP_FIXED) && i_negative &&
                                     ((i_whole != '0) || (i_fraction != '0));
                    n_job.fraction = i_fraction;
                    n_job.bcd      = '0;
                    n_bin          = i_whole;
                    n_cnt          = CNT_W'(WHOLE_BITS - 1);
                    n_state        = DB_RUN;
                end
            end
            DB_RUN: begin
                n_job.bcd = {v_adj[BCD_BITS-2:0], r_bin[WHOLE_BITS-1]};
                n_bin     = {r_bin[WHOLE_BITS-2:0], 1'b0};
                n_cnt     = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = DB_DONE;
                end
            end
            DB_DONE: begin
                if (i_ready) begin
                    n_state = DB_IDLE;
                end
            end
            default: n_state = DB_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DB_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
        r_bin <= n_bin;
        r_job <= n_job;
    end

    assign o_ready = (r_state == DB_IDLE);
    assign o_valid = (r_state == DB_DONE);
    assign o_job   = r_job;

endmodule

[rtl/bdaf_emit.sv]
module bdaf_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bdaf_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_char_out,
    output logic           o_last
);
    import bdaf_pkg::*;

    localparam logic [2:0] EM_IDLE  = 3'd0;
    localparam logic [2:0] EM_SKIP  = 3'd1;
    localparam logic [2:0] EM_SIGN  = 3'd2;
    localparam logic [2:0] EM_WHOLE = 3'd3;
    localparam logic [2:0] EM_POINT = 3'd4;
    localparam logic [2:0] EM_FRAC  = 3'd5;

    logic [2:0]               r_state, n_state;
    logic [BCD_BITS-1:0]      r_bcd, n_bcd;
    logic [FRACTION_BITS-1:0] r_frac, n_frac;
    logic                     r_op, n_op;
    logic                     r_minus, n_minus;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic [FCNT_W-1:0]        r_fcnt, n_fcnt;
    logic                     r_ovalid, n_ovalid;
    logic [7:0]               r_char, n_char;
    logic                     r_last, n_last;

    logic                     v_free;
    logic [3:0]               v_digit;
    logic [FRACTION_BITS+3:0] v_prod;

    // Output register may be loaded when empty or being drained
    assign v_free  = !r_ovalid || i_ready;
    assign v_digit = r_bcd[{r_idx, 2'b00} +: 4];

    // Multiply remaining fraction by ten with a shift-add
    assign v_prod = ({4'b0000, r_frac} << 3) + ({4'b0000, r_frac} << 1);

    always_comb begin
        n_state  = r_state;
        n_bcd    = r_bcd;
        n_frac   = r_frac;
        n_op     = r_op;
        n_minus  = r_minus;
        n_idx    = r_idx;
        n_fcnt   = r_fcnt;
        n_ovalid = r_ovalid && !i_ready;
        n_char   = r_char;
        n_last   = r_last;
        unique case (r_state)
            EM_IDLE: begin
                if (i_valid) begin
                    n_bcd   = i_job.bcd;
                    n_frac  = i_job.fraction;
                    n_op    = i_job.opcode;
                    n_minus = i_job.minus;
                    n_idx   = IDX_W'(BCD_DIGITS - 1);
                    n_state = EM_SKIP;
                end
            end
            EM_SKIP: begin
                // drop one leading zero per cycle, keep the units digit
                if ((v_digit == 4'd0) && (r_idx != '0)) begin
                    n_idx = r_idx - 1'b1;
                end else if (r_minus) begin
                    n_state = EM_SIGN;
                end else begin
                    n_state = EM_WHOLE;
                end
            end
            EM_SIGN: begin
                if (v_free) begin
                    n_ovalid = 1'b1;
                    n_char   = ASCII_MINUS;
                    n_last   = 1'b0;
                    n_state  = EM_WHOLE;
                end
            end
            EM_WHOLE: begin
                if (v_free) begin
                    n_ovalid = 1'b1;
                    n_char   = ASCII_ZERO + {4'b0000, v_digit};
                    n_last   = (r_idx == '0) && (r_op == OP_UNSIGNED);
                    if (r_idx != '0) begin
                        n_idx = r_idx - 1'b1;
                    end else if (r_op == OP_FIXED) begin
                        n_state = EM_POINT;
                    end else begin
                        n_state = EM_IDLE;
                    end
                end
            end
            EM_POINT: begin
                if (v_free) begin
                    n_ovalid = 1'b1;
                    n_char   = ASCII_POINT;
                    n_last   = 1'b0;
                    n_fcnt   = '0;
                    n_state  = EM_FRAC;
                end
            end
            EM_FRAC: begin
                if (v_free) begin
                    n_ovalid = 1'b1;
                    n_char   = ASCII_ZERO + {4'b0000, v_prod[FRACTION_BITS+3 -: 4]};
                    n_frac   = v_prod[FRACTION_BITS-1:0];
                    n_last   = (r_fcnt == FCNT_W'(FRACTION_DIGITS - 1));
                    n_fcnt   = r_fcnt + 1'b1;
                    if (r_fcnt == FCNT_W'(FRACTION_DIGITS - 1)) begin
                        n_state = EM_IDLE;
                    end
                end
            end
            default: n_state = EM_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= EM_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_bcd   <= n_bcd;
        r_frac  <= n_frac;
        r_op    <= n_op;
        r_minus <= n_minus;
        r_idx   <= n_idx;
        r_fcnt  <= n_fcnt;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_ready    = (r_state == EM_IDLE);
    assign o_valid    = r_ovalid;
    assign o_char_out = r_char;
    assign o_last     = r_last;

endmodule

[rtl/binary_to_decimal_ascii_formatter.sv]
// Binary to decimal ASCII formatter.
// Input words (i_valid/o_ready) carry a mode, a sign, a whole part and a
// Q0.20 fraction. Output words (o_valid/i_ready) carry one ASCII character
// each, most significant first, with o_last on the final character.
// Mode 0 gives the unsigned decimal of the whole part without leading zeros;
// mode 1 adds an optional '-', a '.', and six truncated fraction digits.
// A double-dabble converter shifts one input bit per cycle, then hands its
// result to the character sequencer, which skips leading zeros and then
// registers each character. From the first character on, one character
// leaves per cycle while the receiver takes it; 1 to 18 per word.
// The converter accepts the next word as soon as its result has moved to
// the character sequencer, so conversion overlaps emission of the previous
// number.
// A receiver stall holds the output register and pauses the sequencer.
// Reset (synchronous, active low) empties both stages; no word is in flight.
module binary_to_decimal_ascii_formatter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_opcode,
    input  logic                               i_negative,
    input  logic [bdaf_pkg::WHOLE_BITS-1:0]    i_whole,
    input  logic [bdaf_pkg::FRACTION_BITS-1:0] i_fraction,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [7:0]                         o_char_out,
    output logic                               o_last
);
    import bdaf_pkg::*;

    t_job w_job;
    logic w_job_valid;
    logic w_job_ready;

    // Convert the whole part to BCD, one bit per cycle
    bdaf_dabble u_dabble (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_opcode   (i_opcode),
        .i_negative (i_negative),
        .i_whole    (i_whole),
        .i_fraction (i_fraction),
        .o_valid    (w_job_valid),
        .i_ready    (w_job_ready),
        .o_job      (w_job)
    );

    // Emit characters one per cycle through the output register while the receiver takes them
    bdaf_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_job_valid),
        .o_ready    (w_job_ready),
        .i_job      (w_job),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_char_out (o_char_out),
        .o_last     (o_last)
    );

endmodule

[rtl/bdaf_checker.sv]
`include "binary_to_decimal_ascii_formatter_defines.svh"

module bdaf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_char_out,
    input logic       o_last
);
    import bdaf_pkg::*;

    logic w_is_sym;
    logic w_is_char;

    // Classify the output character
    assign w_is_sym  = (o_char_out == ASCII_MINUS) || (o_char_out == ASCII_POINT);
    assign w_is_char = w_is_sym ||
                       ((o_char_out >= ASCII_ZERO) && (o_char_out <= ASCII_NINE));

    // Hold a stalled output word
    `BDAF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_char_out) && $stable(o_last))

    // Converter is busy right after taking a word
    `BDAF_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

    // Only digits, minus and point leave the block
    `BDAF_ASSERT_IMP(a_char_set, i_clk, i_rst_n, o_valid, w_is_char)

    // A number never ends on a sign or a point
    `BDAF_ASSERT_IMP(a_sym_not_last, i_clk, i_rst_n, o_valid && w_is_sym, !o_last)

endmodule

bind binary_to_decimal_ascii_formatter bdaf_checker u_bdaf_checker (.*);
